FILE: rtl/core/telemetry_record_cbor_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry record CBOR encoder
// Concurrent assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_RECORD_CBOR_ENCODER_TOP_ASSERT_SVH
`define TELEMETRY_RECORD_CBOR_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TRCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TRCE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TRCE_ASSERT(label, prop, msg)
`define TRCE_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/core/trce_pkg.sv
// ----------------------------------------------------------------------------
// trce_pkg
// Shared types, CBOR codes and key text for the telemetry record encoder.
// ----------------------------------------------------------------------------
package trce_pkg;

    localparam int RBUF_DEPTH = 4;

    localparam logic [7:0]  HDR_MAP5   = 8'hA5;
    localparam logic [7:0]  CBOR_U32   = 8'h1A;
    localparam logic [7:0]  CBOR_TEXT  = 8'h60;
    localparam logic [7:0]  CBOR_NEG   = 8'h20;
    localparam logic [7:0]  CBOR_NEG8  = 8'h38;
    localparam logic [7:0]  CBOR_NEG16 = 8'h39;
    localparam logic [15:0] MIN_SPACE  = 16'd96;
    localparam logic [31:0] SMALL_LIM  = 32'd24;

    localparam int KEY_COUNT = 5;
    localparam int KEY_MAX   = 14;
    localparam int VAL_COUNT = 5;
    localparam int ENC_MAX   = 5;

    localparam logic [3:0] SEG_HDR  = 4'd0;
    localparam logic [3:0] SEG_LAST = 4'd10;

    // ASCII key text, first character in the highest used byte
    localparam logic [8*KEY_MAX-1:0] KEY_TEXT [KEY_COUNT] = '{
        112'h68_65_61_70_5f_66_72_65_65,
        112'h68_65_61_70_5f_6d_69_6e_5f_66_72_65_65,
        112'h77_69_66_69_5f_72_73_73_69,
        112'h62_61_74_74_65_72_79_5f_6d_76,
        112'h63_70_75_5f_74_65_6d_70_5f_63
    };
    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd9, 4'd13, 4'd9, 4'd10, 4'd10};

    typedef struct packed {
        logic [15:0]        space_available;
        logic signed [15:0] core_temperature;
        logic [15:0]        battery_millivolts;
        logic signed [15:0] link_strength;
        logic [31:0]        heap_low_water;
        logic [31:0]        free_heap_bytes;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } rbuf_out_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       second_valid;
        logic       refused;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [2:0]                 len;
        logic [ENC_MAX-1:0][7:0]    data;
    } enc_t;

    typedef enc_t [VAL_COUNT-1:0] enc_arr_t;

    typedef struct packed {
        logic [3:0] seg;
        logic [3:0] off;
    } cur_t;

endpackage

FILE: rtl/core/telemetry_record_cbor_encoder_top.sv
// ----------------------------------------------------------------------------
// telemetry_record_cbor_encoder_top: telemetry record to CBOR map encoder
// The byte cursor gives one result item per cycle unless m_tready holds the
// output register; a refused record gives a single item. Reset clears queue
// pointers, cursor and output register; the record memory is not cleared.
// ----------------------------------------------------------------------------
`include "telemetry_record_cbor_encoder_top_assert.svh"

module telemetry_record_cbor_encoder_top
    import trce_pkg::*;
#(
    parameter int FIFO_DEPTH = RBUF_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // free_heap_bytes, heap_low_water, link_strength, battery_millivolts,
    // core_temperature, space_available
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // first_byte, second_byte
    output logic [15:0]  m_tdata,
    // second_valid, refused
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    rec_t      in_rec;
    rbuf_out_t rbuf_out;
    logic      rbuf_take;
    res_t      res;
    logic      frame_open_reg, frame_open_next;

    always_comb
    begin
        in_rec.free_heap_bytes    = s_tdata[31:0];
        in_rec.heap_low_water     = s_tdata[63:32];
        in_rec.link_strength      = s_tdata[79:64];
        in_rec.battery_millivolts = s_tdata[95:80];
        in_rec.core_temperature   = s_tdata[111:96];
        in_rec.space_available    = s_tdata[127:112];
    end

    trce_rec_buf #(
        .DEPTH (FIFO_DEPTH)
    ) u_rec_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_rec   (in_rec),
        .take     (rbuf_take),
        .out      (rbuf_out)
    );

    trce_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_in    (rbuf_out),
        .take      (rbuf_take),
        .out_ready (m_tready),
        .res       (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {res.second_byte, res.first_byte};
    assign m_tuser  = {res.refused, res.second_valid};
    assign m_tlast  = res.last;

    assign frame_open_next = (m_tvalid && m_tready) ? !m_tlast : frame_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

    `TRCE_ASSERT(a_refused_alone,
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 16'h0000),
        "refused item not a lone empty last item")
    `TRCE_ASSERT_NEVER(a_odd_not_last,
        m_tvalid && !m_tuser[0] && !m_tuser[1] && !m_tlast,
        "single-byte item before end of record")
    `TRCE_ASSERT(a_map_header,
        m_tvalid && !frame_open_reg && !m_tuser[1] |-> (m_tdata == {CBOR_TEXT + 8'd9, HDR_MAP5}),
        "record does not open with map header and first key")

endmodule

FILE: rtl/core/trce_rec_buf.sv
// ----------------------------------------------------------------------------
// trce_rec_buf
// Record queue held in a synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module trce_rec_buf
    import trce_pkg::*;
#(
    parameter int DEPTH = RBUF_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rec_t      in_rec,
    input  logic      take,
    output rbuf_out_t out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    rec_t             rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             wr_en;
    logic             rd_en;

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign wr_en    = in_valid && in_ready;
    assign rd_en    = (count_reg != '0) && (!rd_valid_reg || take);

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next    = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        rd_valid_next = rd_en ? 1'b1 : (take ? 1'b0 : rd_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= in_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign out.valid = rd_valid_reg;
    assign out.rec   = rd_data_reg;

endmodule

FILE: rtl/core/trce_emit.sv
// ----------------------------------------------------------------------------
// trce_emit
// Value encoding and byte cursor; emits up to two encoded bytes per item.
// ----------------------------------------------------------------------------
module trce_emit
    import trce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rbuf_out_t rec_in,
    output logic      take,
    input  logic      out_ready,
    output res_t      res
);

    function automatic enc_t enc_unsigned(input logic [31:0] v);
        enc_t e;
        e = '0;
        if (v < SMALL_LIM)
        begin
            e.len     = 3'd1;
            e.data[0] = v[7:0];
        end
        else
        begin
            e.len     = 3'd5;
            e.data[0] = CBOR_U32;
            e.data[1] = v[31:24];
            e.data[2] = v[23:16];
            e.data[3] = v[15:8];
            e.data[4] = v[7:0];
        end
        return e;
    endfunction

    function automatic enc_t enc_signed16(input logic [15:0] s);
        enc_t        e;
        logic [15:0] n;
        e = '0;
        n = ~s;
        if (!s[15])
        begin
            e = enc_unsigned({16'd0, s});
        end
        else if (n < SMALL_LIM[15:0])
        begin
            e.len     = 3'd1;
            e.data[0] = CBOR_NEG + n[7:0];
        end
        else if (n[15:8] == 8'd0)
        begin
            e.len     = 3'd2;
            e.data[0] = CBOR_NEG8;
            e.data[1] = n[7:0];
        end
        else
        begin
            e.len     = 3'd3;
            e.data[0] = CBOR_NEG16;
            e.data[1] = n[15:8];
            e.data[2] = n[7:0];
        end
        return e;
    endfunction

    function automatic logic [3:0] seg_len(input enc_arr_t enc, input logic [3:0] seg);
        logic [3:0] len;
        if (seg == SEG_HDR)
        begin
            len = 4'd1;
        end
        else if (seg > SEG_LAST)
        begin
            len = 4'd1;
        end
        else if (seg[0])
        begin
            len = KEY_LEN[seg[3:1]] + 4'd1;
        end
        else
        begin
            len = {1'b0, enc[seg[3:1] - 3'd1].len};
        end
        return len;
    endfunction

    function automatic logic [7:0] byte_at(input enc_arr_t enc, input cur_t c);
        logic [7:0] b;
        logic [3:0] pos;
        b   = '0;
        pos = '0;
        if (c.seg == SEG_HDR)
        begin
            b = HDR_MAP5;
        end
        else if (c.seg > SEG_LAST)
        begin
            b = '0;
        end
        else if (c.seg[0])
        begin
            if (c.off == 4'd0)
            begin
                b = CBOR_TEXT + {4'd0, KEY_LEN[c.seg[3:1]]};
            end
            else
            begin
                pos = KEY_LEN[c.seg[3:1]] - c.off;
                b   = KEY_TEXT[c.seg[3:1]][{pos, 3'b000} +: 8];
            end
        end
        else
        begin
            b = enc[c.seg[3:1] - 3'd1].data[c.off[2:0]];
        end
        return b;
    endfunction

    logic     job_valid_reg, job_valid_next;
    logic     refused_reg, refused_next;
    cur_t     cur_reg, cur_next;
    enc_arr_t enc_reg, enc_next;
    res_t     res_reg, res_next;

    cur_t     cur_b;
    cur_t     cur_c;
    logic     a_end, a_last;
    logic     b_end, b_last;
    logic     emit;
    logic     job_done;
    logic     load;

    always_comb
    begin
        a_end  = (cur_reg.off + 4'd1) == seg_len(enc_reg, cur_reg.seg);
        a_last = a_end && (cur_reg.seg == SEG_LAST);
        cur_b  = a_end ? cur_t'{seg: cur_reg.seg + 4'd1, off: 4'd0}
                       : cur_t'{seg: cur_reg.seg, off: cur_reg.off + 4'd1};
        b_end  = (cur_b.off + 4'd1) == seg_len(enc_reg, cur_b.seg);
        b_last = b_end && (cur_b.seg == SEG_LAST);
        cur_c  = b_end ? cur_t'{seg: cur_b.seg + 4'd1, off: 4'd0}
                       : cur_t'{seg: cur_b.seg, off: cur_b.off + 4'd1};
    end

    assign emit     = job_valid_reg && (!res_reg.valid || out_ready);
    assign job_done = emit && (refused_reg || a_last || b_last);
    assign load     = rec_in.valid && (!job_valid_reg || job_done);
    assign take     = load;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        refused_next   = refused_reg;
        cur_next       = cur_reg;
        enc_next       = enc_reg;
        res_next       = res_reg;

        if (out_ready)
        begin
            res_next.valid = 1'b0;
        end

        if (emit)
        begin
            res_next.valid = 1'b1;
            if (refused_reg)
            begin
                res_next.first_byte   = '0;
                res_next.second_byte  = '0;
                res_next.second_valid = 1'b0;
                res_next.refused      = 1'b1;
                res_next.last         = 1'b1;
            end
            else if (a_last)
            begin
                res_next.first_byte   = byte_at(enc_reg, cur_reg);
                res_next.second_byte  = '0;
                res_next.second_valid = 1'b0;
                res_next.refused      = 1'b0;
                res_next.last         = 1'b1;
            end
            else
            begin
                res_next.first_byte   = byte_at(enc_reg, cur_reg);
                res_next.second_byte  = byte_at(enc_reg, cur_b);
                res_next.second_valid = 1'b1;
                res_next.refused      = 1'b0;
                res_next.last         = b_last;
            end
            cur_next = cur_c;
        end

        if (job_done)
        begin
            job_valid_next = 1'b0;
        end

        if (load)
        begin
            job_valid_next = 1'b1;
            refused_next   = rec_in.rec.space_available < MIN_SPACE;
            cur_next       = '{seg: SEG_HDR, off: 4'd0};
            enc_next[0]    = enc_unsigned(rec_in.rec.free_heap_bytes);
            enc_next[1]    = enc_unsigned(rec_in.rec.heap_low_water);
            enc_next[2]    = enc_signed16(rec_in.rec.link_strength);
            enc_next[3]    = enc_unsigned({16'd0, rec_in.rec.battery_millivolts});
            enc_next[4]    = enc_signed16(rec_in.rec.core_temperature);
        end
    end

    always_ff @(posedge clk)
    begin
        enc_reg     <= enc_next;
        refused_reg <= refused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            cur_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            cur_reg       <= cur_next;
            res_reg       <= res_next;
        end
    end

    assign res = res_reg;

endmodule
